// ----- rtl/pls_pkg.sv -----
// Package for the positional list store: request and result types, codes and sizes.
// Depends on nothing; pls_ctrl, positional_list_store and pls_checker use it.
`default_nettype none

package pls_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int ENTRY_WIDTH_DEF = 32;
	localparam int POS_W           = 5;
	localparam int COUNT_W         = 5;
	localparam int DATA_W          = 32;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_RM_LAST = 2'd2,
		REQ_RM_POS = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BADPOS = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_RD,
		S_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		req_code_t           req_type;
		logic [POS_W-1:0]    position;
		logic [DATA_W-1:0]   entry_data;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/pls_mem.sv -----
// Entry store of the positional list: one write port and one read port with registered data.
// Depends on nothing outside this file.
`default_nettype none

module pls_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/pls_ctrl.sv -----
// Sequencer of the positional list store: checks a request, then shifts entries one
// at a time through the entry store with a shared increment/decrement unit.
// Depends on pls_pkg.
`default_nettype none

module pls_ctrl #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
	parameter int ENTRY_WIDTH = pls_pkg::ENTRY_WIDTH_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire pls_pkg::req_t          request,
	output logic                        busy,
	output logic                        done,
	output pls_pkg::rsp_t               result,
	output logic                        mem_we,
	output logic      [AW-1:0]          mem_waddr,
	output logic      [ENTRY_WIDTH-1:0] mem_wdata,
	output logic      [AW-1:0]          mem_raddr,
	input  wire logic [ENTRY_WIDTH-1:0] mem_rdata
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;

	pls_pkg::state_t          state_q, state_d;
	pls_pkg::req_code_t       op_q;
	logic [pls_pkg::POS_W-1:0] pos_q;
	logic [ENTRY_WIDTH-1:0]   data_q;
	pls_pkg::status_t         status_q, eval_status;
	logic [CNT_W-1:0]         count_q, idx_q, lim_q;
	logic [CNT_W-1:0]         eval_idx, eval_lim;
	logic                     eval_shift;
	logic                     done_q;
	pls_pkg::rsp_t            rsp_q;

	// Shared step unit: one increment or decrement of the selected operand.
	logic [CNT_W-1:0]         opa, sum;
	logic                     down;
	logic                     is_ins;

	assign sum    = down ? (opa - CNT_W'(1)) : (opa + CNT_W'(1));
	assign is_ins = (op_q == pls_pkg::REQ_APPEND) || (op_q == pls_pkg::REQ_INSERT);

	// Request checks, made in the evaluation cycle while the unit forms count - 1.
	always_comb begin
		logic [CMP_W-1:0] pos_x, cnt_x;
		logic             pos_gt, pos_eq, cnt_zero, cnt_full;
		pos_x    = CMP_W'(pos_q);
		cnt_x    = CMP_W'(count_q);
		pos_gt   = pos_x > cnt_x;
		pos_eq   = pos_x == cnt_x;
		cnt_zero = count_q == '0;
		cnt_full = count_q == CNT_W'(CAPACITY);
		eval_status = pls_pkg::ST_OK;
		eval_idx    = count_q;
		eval_lim    = count_q;
		unique case (op_q)
			pls_pkg::REQ_APPEND: begin
				if (cnt_full) begin
					eval_status = pls_pkg::ST_FULL;
				end
			end
			pls_pkg::REQ_INSERT: begin
				eval_lim = CNT_W'(pos_q);
				priority if (pos_gt) begin
					eval_status = pls_pkg::ST_BADPOS;
				end else if (cnt_full) begin
					eval_status = pls_pkg::ST_FULL;
				end
			end
			pls_pkg::REQ_RM_LAST: begin
				eval_idx = sum;
				eval_lim = sum;
				if (cnt_zero) begin
					eval_status = pls_pkg::ST_EMPTY;
				end
			end
			pls_pkg::REQ_RM_POS: begin
				eval_idx = CNT_W'(pos_q);
				eval_lim = sum;
				priority if (pos_gt) begin
					eval_status = pls_pkg::ST_BADPOS;
				end else if (cnt_zero) begin
					eval_status = pls_pkg::ST_EMPTY;
				end else if (pos_eq) begin
					eval_status = pls_pkg::ST_BADPOS;
				end
			end
			default: begin
				eval_status = pls_pkg::ST_OK;
			end
		endcase
		eval_shift = (eval_status == pls_pkg::ST_OK) && (eval_idx != eval_lim);
	end

	always_comb begin
		state_d   = state_q;
		opa       = count_q;
		down      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = sum[AW-1:0];
		unique case (state_q)
			pls_pkg::S_IDLE: begin
				if (start) begin
					state_d = pls_pkg::S_EVAL;
				end
			end
			pls_pkg::S_EVAL: begin
				down    = 1'b1;
				state_d = eval_shift ? pls_pkg::S_RD : pls_pkg::S_DONE;
			end
			pls_pkg::S_RD: begin
				opa     = idx_q;
				down    = is_ins;
				state_d = pls_pkg::S_WR;
			end
			pls_pkg::S_WR: begin
				opa     = idx_q;
				down    = is_ins;
				mem_we  = 1'b1;
				state_d = (sum != lim_q) ? pls_pkg::S_RD : pls_pkg::S_DONE;
			end
			pls_pkg::S_DONE: begin
				down      = !is_ins;
				mem_we    = is_ins && (status_q == pls_pkg::ST_OK);
				mem_waddr = lim_q[AW-1:0];
				mem_wdata = data_q;
				state_d   = pls_pkg::S_IDLE;
			end
			default: begin
				state_d = pls_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pls_pkg::S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == pls_pkg::S_DONE;
			if ((state_q == pls_pkg::S_DONE) && (status_q == pls_pkg::ST_OK)) begin
				count_q <= sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pls_pkg::S_IDLE: begin
				op_q   <= request.req_type;
				pos_q  <= request.position;
				data_q <= ENTRY_WIDTH'(request.entry_data);
			end
			pls_pkg::S_EVAL: begin
				status_q <= eval_status;
				idx_q    <= eval_idx;
				lim_q    <= eval_lim;
			end
			pls_pkg::S_WR: begin
				idx_q <= sum;
			end
			pls_pkg::S_DONE: begin
				rsp_q.status      <= status_q;
				rsp_q.entry_count <= (status_q == pls_pkg::ST_OK) ?
					pls_pkg::COUNT_W'(sum) : pls_pkg::COUNT_W'(count_q);
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign busy   = state_q != pls_pkg::S_IDLE;
	assign done   = done_q;
	assign result = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/positional_list_store.sv -----
// Positional list store: one request at a time. An accepted request passes through the
// evaluation state, a read state and a write state for each shifted entry (0 to CAPACITY-1
// of them) and the final state; done and the result are registered from the final state.
// No new request is taken while busy. The step unit and the registered read of the entry
// store serve one move at a time. A request may be accepted in the cycle that carries the
// previous result. Reset clears the entry count and the sequencer only.
`default_nettype none

module positional_list_store #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF,
	parameter int ENTRY_WIDTH = pls_pkg::ENTRY_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire pls_pkg::req_t request,
	output logic               busy,
	output logic               done,
	output pls_pkg::rsp_t      result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// The sequencer drives the entry store directly. An insert walks from the tail down
	// to the target position, moving each entry one cell up; a removal walks from the
	// target position up to the tail, moving each entry one cell down. The new entry of
	// an insert or append is written in the final cycle, when the count is updated.
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [ENTRY_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]          mem_raddr;
	logic [ENTRY_WIDTH-1:0] mem_rdata;

	pls_ctrl #(
		.CAPACITY(CAPACITY),
		.ENTRY_WIDTH(ENTRY_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// Entry cells; only cells below the count are ever read back in a meaningful way.
	pls_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(ENTRY_WIDTH)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

`default_nettype wire

// ----- rtl/pls_checker.sv -----
// Port-level checks for the positional list store, and the bind that attaches them.
// Depends on pls_pkg and on positional_list_store.
`default_nettype none

module pls_checker #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire logic          done,
	input wire pls_pkg::rsp_t result
);

	// A result only appears once the block has gone idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// An accepted request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted request did not raise busy");

	// Every request gives exactly one result; this checks that its strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe lasted more than one cycle");

	// The reported count never exceeds the store size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (int'(result.entry_count) <= CAPACITY)) else $error("count beyond capacity");

	// A full or empty status leaves the count at its limit; the check covers the empty case.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == pls_pkg::ST_EMPTY)) |-> (result.entry_count == '0))
		else $error("empty status with nonzero count");

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);

`default_nettype wire
